/* rtl/c2d_pkg.sv */
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types, constants and codes of the streaming 2D convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;

    // default sizes of storage
    localparam int KERNEL_MAX_DEF = 5;
    localparam int FILTER_MAX_DEF = 8;
    localparam int WIDTH_MAX_DEF  = 1024;
    localparam int HEIGHT_MAX_DEF = 1024;

    // fixed field widths
    localparam int PIX_W   = 16;
    localparam int POS_W   = 10;
    localparam int FIDX_W  = 3;
    localparam int ACT_W   = 15;
    localparam int CFG_W   = 11;

    // queue depths
    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 8;

    // item kinds
    localparam logic CMD_PIXEL  = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // register indexes
    typedef enum logic [2:0] {
        REG_KERNEL_ROWS  = 3'd0,
        REG_KERNEL_COLS  = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_FILTER_COUNT = 3'd4,
        REG_RESULT_SHIFT = 3'd5
    } cfg_reg_t;

    // back end sequencer
    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        logic              cmd;
        logic [2:0]        weight_filter;
        logic [2:0]        weight_row;
        logic [2:0]        weight_col;
        logic signed [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [FIDX_W-1:0] filter_index;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic [ACT_W-1:0]  activation;
        logic              last;
    } out_item_t;

    // clamped configuration
    typedef struct packed {
        logic [2:0]  kr;
        logic [2:0]  kc;
        logic [12:0] iw;
        logic [12:0] ih;
        logic [4:0]  fc;
        logic [4:0]  shift;
    } cfg_t;

    // weight write from front to back
    typedef struct packed {
        logic               en;
        logic [2:0]         filter;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
    } wt_wr_t;

    // output position carried with a window
    typedef struct packed {
        logic [POS_W-1:0] orow;
        logic [POS_W-1:0] ocol;
    } job_meta_t;

endpackage

/* rtl/c2d_fifo.sv */
// ----------------------------------------------------------------------------
// c2d_fifo
// Small register queue; caller checks full and empty.
// ----------------------------------------------------------------------------
module c2d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign count    = count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

/* rtl/c2d_front.sv */
// ----------------------------------------------------------------------------
// c2d_front
// Accepts items, tracks raster position, keeps line stores and the window,
// and hands full aligned windows to the job queue.
// ----------------------------------------------------------------------------
module c2d_front #(
    parameter int KERNEL_MAX = c2d_pkg::KERNEL_MAX_DEF,
    parameter int WIDTH_MAX  = c2d_pkg::WIDTH_MAX_DEF,
    parameter int HEIGHT_MAX = c2d_pkg::HEIGHT_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  c2d_pkg::in_item_t   in_item,
    input  c2d_pkg::cfg_t       cfg,
    input  logic                restart,
    input  logic                job_full,
    input  logic                job_empty,
    input  logic                back_busy,
    output logic                job_push,
    output logic [$bits(c2d_pkg::job_meta_t)+KERNEL_MAX*KERNEL_MAX*c2d_pkg::PIX_W-1:0] job_data,
    output c2d_pkg::wt_wr_t     wt_wr
);
    localparam int KM = KERNEL_MAX;
    localparam int LR = (KM > 1) ? KM - 1 : 1;
    localparam int KW = (KM > 1) ? $clog2(KM) : 1;
    localparam int AW = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
    localparam int RW = (HEIGHT_MAX > 1) ? $clog2(HEIGHT_MAX) : 1;
    localparam int PW = ((AW > RW) ? AW : RW) + 2;
    localparam int OW = c2d_pkg::POS_W;
    localparam int XW = c2d_pkg::PIX_W;

    logic [XW-1:0] line_mem [LR][WIDTH_MAX];
    logic [XW-1:0] rd_reg [LR];
    logic [XW-1:0] win_reg [KM][KM];
    logic [XW-1:0] win_next [KM][KM];
    logic [XW-1:0] vec [KM];
    logic [KM*KM*XW-1:0] pix_flat;

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] col_count_reg, col_count_next, col_w;
    logic [RW-1:0] row_count_reg, row_count_next, row_w;

    logic                s2_valid_reg;
    logic [XW-1:0]       s2_sample_reg;
    logic [AW-1:0]       s2_col_reg;
    logic                s2_emit_reg;
    c2d_pkg::job_meta_t  s2_meta_reg;

    logic               accept, pix_acc, emit;
    logic [PW-1:0]      orow_full, ocol_full;
    c2d_pkg::job_meta_t meta;

    // handshake
    always_comb
    begin
        in_ready = !clr_busy_reg && !s2_valid_reg &&
                   ((in_item.cmd == c2d_pkg::CMD_WEIGHT) ? (job_empty && !back_busy)
                                                         : !job_full);
    end
    assign accept  = in_valid && in_ready;
    assign pix_acc = accept && (in_item.cmd == c2d_pkg::CMD_PIXEL);

    // weight writes go straight to the back end
    always_comb
    begin
        wt_wr.en     = accept && (in_item.cmd == c2d_pkg::CMD_WEIGHT);
        wt_wr.filter = in_item.weight_filter;
        wt_wr.row    = in_item.weight_row;
        wt_wr.col    = in_item.weight_col;
        wt_wr.value  = in_item.sample;
    end

    // position of this pixel and the next one
    always_comb
    begin
        col_w = (PW'(col_count_reg) >= PW'(cfg.iw)) ? '0 : col_count_reg;
        row_w = (PW'(row_count_reg) >= PW'(cfg.ih)) ? '0 : row_count_reg;
        emit  = (PW'(row_w) + PW'(1) >= PW'(cfg.kr)) &&
                (PW'(col_w) + PW'(1) >= PW'(cfg.kc));
        orow_full = PW'(row_w) + PW'(1) - PW'(cfg.kr);
        ocol_full = PW'(col_w) + PW'(1) - PW'(cfg.kc);
        meta.orow = OW'(orow_full);
        meta.ocol = OW'(ocol_full);
        col_count_next = col_w + AW'(1);
        row_count_next = row_w;
        if (PW'(col_w) + PW'(1) >= PW'(cfg.iw))
        begin
            col_count_next = '0;
            if (PW'(row_w) + PW'(1) >= PW'(cfg.ih))
            begin
                row_count_next = '0;
            end
            else
            begin
                row_count_next = row_w + RW'(1);
            end
        end
    end

    // position, pixel stage and clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s2_valid_reg  <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (restart)
            begin
                col_count_reg <= '0;
                row_count_reg <= '0;
            end
            else if (pix_acc)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
            s2_valid_reg <= pix_acc;
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == AW'(WIDTH_MAX - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end
        end
    end

    // pixel stage payload
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s2_sample_reg <= in_item.sample;
            s2_col_reg    <= col_w;
            s2_emit_reg   <= emit;
            s2_meta_reg   <= meta;
        end
    end

    // line stores: read on accept, written back in the next cycle
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            for (int b = 0; b < LR; b++)
            begin
                line_mem[b][clr_addr_reg] <= '0;
            end
        end
        else if (s2_valid_reg)
        begin
            for (int b = 0; b < LR; b++)
            begin
                line_mem[b][s2_col_reg] <= vec[b];
            end
        end
        if (pix_acc)
        begin
            for (int b = 0; b < LR; b++)
            begin
                rd_reg[b] <= line_mem[b][col_w];
            end
        end
    end

    // column vector, newest row first
    always_comb
    begin
        vec[0] = s2_sample_reg;
        for (int k = 1; k < KM; k++)
        begin
            vec[k] = rd_reg[k-1];
        end
    end

    // window shift, newest column first
    always_comb
    begin
        for (int k = 0; k < KM; k++)
        begin
            win_next[k][0] = vec[k];
            for (int c = 1; c < KM; c++)
            begin
                win_next[k][c] = win_reg[k][c-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KM; k++)
            begin
                for (int c = 0; c < KM; c++)
                begin
                    win_reg[k][c] <= '0;
                end
            end
        end
        else if (s2_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // align window to weight order, zero outside the kernel
    always_comb
    begin
        int ri;
        int cj;
        pix_flat = '0;
        for (int ii = 0; ii < KM; ii++)
        begin
            for (int jj = 0; jj < KM; jj++)
            begin
                ri = int'(cfg.kr) - 1 - ii;
                cj = int'(cfg.kc) - 1 - jj;
                if (ri >= 0 && cj >= 0)
                begin
                    pix_flat[(ii*KM+jj)*XW +: XW] = win_next[ri[KW-1:0]][cj[KW-1:0]];
                end
            end
        end
    end

    assign job_push = s2_valid_reg && s2_emit_reg;
    assign job_data = {s2_meta_reg, pix_flat};

endmodule

/* rtl/c2d_back.sv */
// ----------------------------------------------------------------------------
// c2d_back
// Holds the weights and runs one window through every configured filter: products,
// row sums, total, then shift, ReLU and saturation into the result queue.
// ----------------------------------------------------------------------------
module c2d_back #(
    parameter int KERNEL_MAX = c2d_pkg::KERNEL_MAX_DEF,
    parameter int FILTER_MAX = c2d_pkg::FILTER_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  c2d_pkg::cfg_t      cfg,
    input  c2d_pkg::wt_wr_t    wt_wr,
    input  logic               job_empty,
    input  logic [$bits(c2d_pkg::job_meta_t)+KERNEL_MAX*KERNEL_MAX*c2d_pkg::PIX_W-1:0] job_data,
    output logic               job_pop,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_ready,
    output c2d_pkg::out_item_t out_item
);
    localparam int KM    = KERNEL_MAX;
    localparam int KW    = (KM > 1) ? $clog2(KM) : 1;
    localparam int FW    = (FILTER_MAX > 1) ? $clog2(FILTER_MAX) : 1;
    localparam int XW    = c2d_pkg::PIX_W;
    localparam int JW    = $bits(c2d_pkg::job_meta_t) + KM*KM*XW;
    localparam int SUM_W = 2*XW + $clog2(KM*KM + 1) + 1;
    localparam int OD    = c2d_pkg::OUT_DEPTH;
    localparam int CW    = $clog2(OD + 1);
    localparam int AW    = c2d_pkg::ACT_W;

    typedef struct packed {
        logic [c2d_pkg::FIDX_W-1:0] fidx;
        c2d_pkg::job_meta_t         pos;
        logic                       last;
    } stage_meta_t;

    c2d_pkg::back_state_t state_reg, state_next;

    logic signed [XW-1:0]    weight_reg [FILTER_MAX][KM][KM];
    logic [JW-1:0]           job_reg;
    logic [FW-1:0]           f_reg;
    logic                    issue, last_f, credit_ok;

    logic signed [2*XW-1:0]  prod_reg [KM][KM];
    logic signed [SUM_W-1:0] row_sum_reg [KM];
    logic signed [SUM_W-1:0] row_sum_next [KM];
    logic signed [SUM_W-1:0] total_reg, total_next;
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    stage_meta_t             s1_meta_reg, s2_meta_reg, s3_meta_reg;

    logic [SUM_W-1:0]        shifted;
    logic [AW-1:0]           act;
    c2d_pkg::out_item_t      res;
    logic [CW-1:0]           out_count;
    logic                    out_empty, out_full;
    logic [$bits(c2d_pkg::out_item_t)-1:0] out_data;

    // weight store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FILTER_MAX; f++)
            begin
                for (int i = 0; i < KM; i++)
                begin
                    for (int j = 0; j < KM; j++)
                    begin
                        weight_reg[f][i][j] <= '0;
                    end
                end
            end
        end
        else if (wt_wr.en && (int'(wt_wr.filter) < FILTER_MAX) &&
                 (int'(wt_wr.row) < KM) && (int'(wt_wr.col) < KM))
        begin
            weight_reg[FW'(wt_wr.filter)][KW'(wt_wr.row)][KW'(wt_wr.col)] <= wt_wr.value;
        end
    end

    // room in the result queue for everything in flight
    always_comb
    begin
        credit_ok = (out_count + CW'(s1_valid_reg) + CW'(s2_valid_reg) +
                     CW'(s3_valid_reg)) < CW'(OD);
        last_f    = (5'(f_reg) + 5'd1 == cfg.fc);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c2d_pkg::BK_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = c2d_pkg::BK_RUN;
                end
            end
            c2d_pkg::BK_RUN:
            begin
                if (credit_ok && last_f)
                begin
                    state_next = c2d_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = c2d_pkg::BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        job_pop = 1'b0;
        issue   = 1'b0;
        busy    = 1'b0;
        case (state_reg)
            c2d_pkg::BK_IDLE:
            begin
                job_pop = !job_empty;
            end
            c2d_pkg::BK_RUN:
            begin
                issue = credit_ok;
                busy  = 1'b1;
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= c2d_pkg::BK_IDLE;
            f_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_pop)
            begin
                f_reg <= '0;
            end
            else if (issue)
            begin
                f_reg <= f_reg + FW'(1);
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // window held for the whole filter pass
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job_data;
        end
    end

    // products of one filter
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            for (int i = 0; i < KM; i++)
            begin
                for (int j = 0; j < KM; j++)
                begin
                    prod_reg[i][j] <= $signed(job_reg[(i*KM+j)*XW +: XW]) * weight_reg[f_reg][i][j];
                end
            end
            s1_meta_reg.fidx <= c2d_pkg::FIDX_W'(f_reg);
            s1_meta_reg.pos  <= c2d_pkg::job_meta_t'(job_reg[JW-1 -: $bits(c2d_pkg::job_meta_t)]);
            s1_meta_reg.last <= last_f;
        end
    end

    // row sums
    always_comb
    begin
        for (int i = 0; i < KM; i++)
        begin
            row_sum_next[i] = '0;
            for (int j = 0; j < KM; j++)
            begin
                row_sum_next[i] = row_sum_next[i] + SUM_W'(prod_reg[i][j]);
            end
        end
    end

    // total of row sums
    always_comb
    begin
        total_next = '0;
        for (int i = 0; i < KM; i++)
        begin
            total_next = total_next + row_sum_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        row_sum_reg <= row_sum_next;
        s2_meta_reg <= s1_meta_reg;
        total_reg   <= total_next;
        s3_meta_reg <= s2_meta_reg;
    end

    // shift, relu, saturate
    always_comb
    begin
        shifted = $unsigned(total_reg) >> cfg.shift;
        if (total_reg[SUM_W-1] || (total_reg == '0))
        begin
            act = '0;
        end
        else if (|shifted[SUM_W-1:AW])
        begin
            act = '1;
        end
        else
        begin
            act = shifted[AW-1:0];
        end
        res.filter_index = s3_meta_reg.fidx;
        res.out_row      = s3_meta_reg.pos.orow;
        res.out_col      = s3_meta_reg.pos.ocol;
        res.activation   = act;
        res.last         = s3_meta_reg.last;
    end

    // result queue
    c2d_fifo #(
        .WIDTH ($bits(c2d_pkg::out_item_t)),
        .DEPTH (OD)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data (res),
        .pop       (out_valid && out_ready),
        .pop_data  (out_data),
        .empty     (out_empty),
        .full      (out_full),
        .count     (out_count)
    );

    assign out_valid = !out_empty;
    assign out_item  = c2d_pkg::out_item_t'(out_data);

    // full is covered by the credit check
    logic unused_full;
    assign unused_full = out_full;

endmodule

/* rtl/conv2d_valid_relu_stream.sv */
// ----------------------------------------------------------------------------
// conv2d_valid_relu_stream
// Valid 2D convolution of one pixel stream with a bank of filters and ReLU.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item) carries pixels in raster order
// (cmd pixel) or single weight writes (cmd weight). Output channel
// (out_valid/out_ready/out_item) gives one result per filter for every
// pixel that completes a kernel window, filter 0 first, last set on the
// final filter.
// A pixel is read from the line stores as it is taken and written back in
// the next cycle; the pixel port takes no new item before that write-back.
// A window is then queued and fetched by the filter unit when it is idle,
// and passes through it at one filter per cycle while the result queue has
// room; each result goes through the product, row sum and total registers
// before it enters the result queue and is offered.
// Weight writes wait until the filter unit has no window left.
// The front and the filter unit are decoupled by a two-entry queue, and
// results wait in an eight-entry queue, so a stalled receiver backs up the
// filter unit first and only then the input.
// After reset the line stores are cleared, one column a cycle, across all
// WIDTH_MAX columns (1024 by default); in_ready stays low meanwhile.
// Configuration writes (cfg_we) are taken at any time and must only be
// issued while the block is idle.
// ----------------------------------------------------------------------------
module conv2d_valid_relu_stream #(
    parameter int KERNEL_MAX = c2d_pkg::KERNEL_MAX_DEF,
    parameter int FILTER_MAX = c2d_pkg::FILTER_MAX_DEF,
    parameter int WIDTH_MAX  = c2d_pkg::WIDTH_MAX_DEF,
    parameter int HEIGHT_MAX = c2d_pkg::HEIGHT_MAX_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  c2d_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output c2d_pkg::out_item_t        out_item,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [c2d_pkg::CFG_W-1:0] cfg_data
);
    localparam int JW  = $bits(c2d_pkg::job_meta_t) + KERNEL_MAX*KERNEL_MAX*c2d_pkg::PIX_W;
    localparam int JCW = $clog2(c2d_pkg::JOB_DEPTH + 1);

    logic [2:0]  kernel_rows_reg, kernel_cols_reg;
    logic [10:0] image_width_reg, image_height_reg;
    logic [3:0]  filter_count_reg;
    logic [4:0]  result_shift_reg;
    logic        restart;
    c2d_pkg::cfg_t   cfg;
    c2d_pkg::wt_wr_t wt_wr;

    logic           job_push, job_pop, job_empty, job_full, back_busy;
    logic [JW-1:0]  job_wdata, job_rdata;
    logic [JCW-1:0] job_count;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_rows_reg  <= 3'd3;
            kernel_cols_reg  <= 3'd3;
            image_width_reg  <= 11'd1024;
            image_height_reg <= 11'd1024;
            filter_count_reg <= 4'd8;
            result_shift_reg <= 5'd14;
        end
        else if (cfg_we)
        begin
            case (c2d_pkg::cfg_reg_t'(cfg_index))
                c2d_pkg::REG_KERNEL_ROWS:  kernel_rows_reg  <= cfg_data[2:0];
                c2d_pkg::REG_KERNEL_COLS:  kernel_cols_reg  <= cfg_data[2:0];
                c2d_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                c2d_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[10:0];
                c2d_pkg::REG_FILTER_COUNT: filter_count_reg <= cfg_data[3:0];
                c2d_pkg::REG_RESULT_SHIFT: result_shift_reg <= cfg_data[4:0];
                default:                   result_shift_reg <= result_shift_reg;
            endcase
        end
    end

    // geometry writes restart the frame
    always_comb
    begin
        case (c2d_pkg::cfg_reg_t'(cfg_index))
            c2d_pkg::REG_KERNEL_ROWS,
            c2d_pkg::REG_KERNEL_COLS,
            c2d_pkg::REG_IMAGE_WIDTH,
            c2d_pkg::REG_IMAGE_HEIGHT: restart = cfg_we;
            default:                   restart = 1'b0;
        endcase
    end

    // clamp to the supported ranges
    always_comb
    begin
        cfg.kr = (kernel_rows_reg == '0) ? 3'd1 :
                 (int'(kernel_rows_reg) > KERNEL_MAX) ? 3'(KERNEL_MAX) : kernel_rows_reg;
        cfg.kc = (kernel_cols_reg == '0) ? 3'd1 :
                 (int'(kernel_cols_reg) > KERNEL_MAX) ? 3'(KERNEL_MAX) : kernel_cols_reg;
        cfg.iw = (image_width_reg == '0) ? 13'd1 :
                 (int'(image_width_reg) > WIDTH_MAX) ? 13'(WIDTH_MAX) : 13'(image_width_reg);
        cfg.ih = (image_height_reg == '0) ? 13'd1 :
                 (int'(image_height_reg) > HEIGHT_MAX) ? 13'(HEIGHT_MAX)
                                                        : 13'(image_height_reg);
        cfg.fc = (filter_count_reg == '0) ? 5'd1 :
                 (int'(filter_count_reg) > FILTER_MAX) ? 5'(FILTER_MAX)
                                                        : 5'(filter_count_reg);
        cfg.shift = result_shift_reg;
    end

    c2d_front #(
        .KERNEL_MAX (KERNEL_MAX),
        .WIDTH_MAX  (WIDTH_MAX),
        .HEIGHT_MAX (HEIGHT_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg       (cfg),
        .restart   (restart),
        .job_full  (job_full),
        .job_empty (job_empty),
        .back_busy (back_busy),
        .job_push  (job_push),
        .job_data  (job_wdata),
        .wt_wr     (wt_wr)
    );

    c2d_fifo #(
        .WIDTH (JW),
        .DEPTH (c2d_pkg::JOB_DEPTH)
    ) u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_wdata),
        .pop       (job_pop),
        .pop_data  (job_rdata),
        .empty     (job_empty),
        .full      (job_full),
        .count     (job_count)
    );

    c2d_back #(
        .KERNEL_MAX (KERNEL_MAX),
        .FILTER_MAX (FILTER_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .wt_wr     (wt_wr),
        .job_empty (job_empty),
        .job_data  (job_rdata),
        .job_pop   (job_pop),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // fill level is not needed beyond full and empty
    logic unused_count;
    assign unused_count = |job_count;

endmodule

/* rtl/c2d_checker.sv */
// ----------------------------------------------------------------------------
// c2d_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module c2d_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input c2d_pkg::out_item_t out_item
);
    // a stalled item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled item keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("result changed while stalled");

    // the highest filter index always closes a position
    a_top_filter_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.filter_index == 3'd7) |-> out_item.last)
        else $error("highest filter without last");

endmodule

bind conv2d_valid_relu_stream c2d_checker u_c2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

/* tb/tb_conv2d_valid_relu_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_valid_relu_stream
// Self-checking bench for the streaming valid convolution with ReLU: pixels
// and weight writes go in under random idling, every result is checked in
// order against an in-bench model of the line stores, window and filters.
// ----------------------------------------------------------------------------
module tb_conv2d_valid_relu_stream;

    localparam int KMAX = c2d_pkg::KERNEL_MAX_DEF;
    localparam int FMAX = c2d_pkg::FILTER_MAX_DEF;
    localparam int WMAX = c2d_pkg::WIDTH_MAX_DEF;
    localparam int HMAX = c2d_pkg::HEIGHT_MAX_DEF;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    c2d_pkg::in_item_t         in_item;
    logic                      out_valid;
    logic                      out_ready;
    c2d_pkg::out_item_t        out_item;
    logic                      cfg_we;
    logic [2:0]                cfg_index;
    logic [c2d_pkg::CFG_W-1:0] cfg_data;

    // model state
    logic [15:0]       line_mem [KMAX-1][WMAX];
    logic [15:0]       win [KMAX][KMAX];
    logic [15:0]       wts [FMAX][KMAX][KMAX];
    int unsigned       row_pos;
    int unsigned       col_pos;
    int unsigned       reg_kr, reg_kc, reg_iw, reg_ih, reg_fc, reg_shift;

    c2d_pkg::out_item_t pending_results [$];
    int                n_err;
    int                n_results;
    int                n_pixels;
    int                n_weights;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_cycles;

    conv2d_valid_relu_stream i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(2_000_000 * 10);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // reset state of the model
    task automatic model_clear();
        foreach (line_mem[k, c])
            line_mem[k][c] = '0;
        foreach (win[k, c])
            win[k][c] = '0;
        foreach (wts[f, r, c])
            wts[f][r][c] = '0;
        row_pos   = 0;
        col_pos   = 0;
        reg_kr    = 3;
        reg_kc    = 3;
        reg_iw    = 1024;
        reg_ih    = 1024;
        reg_fc    = 8;
        reg_shift = 14;
    endtask

    // model of one accepted item: queues the filter results it causes
    task automatic conv_predict(c2d_pkg::in_item_t it);
        int unsigned        kr, kc, iw, ih, fc, row, col;
        logic [15:0]        vec [KMAX];
        longint             acc;
        logic [63:0]        act;
        c2d_pkg::out_item_t res;
        kr = clamp_u(reg_kr, 1, KMAX);
        kc = clamp_u(reg_kc, 1, KMAX);
        iw = clamp_u(reg_iw, 1, WMAX);
        ih = clamp_u(reg_ih, 1, HMAX);
        fc = clamp_u(reg_fc, 1, FMAX);
        if (it.cmd == c2d_pkg::CMD_WEIGHT)
        begin
            n_weights++;
            if (it.weight_filter < FMAX && it.weight_row < KMAX && it.weight_col < KMAX)
                wts[it.weight_filter][it.weight_row][it.weight_col] = it.sample;
            return;
        end
        n_pixels++;
        row = row_pos;
        col = col_pos;
        if (col >= iw)
            col = 0;
        if (row >= ih)
            row = 0;
        // column vector, newest row first
        vec[0] = it.sample;
        for (int k = 1; k < KMAX; k++)
            vec[k] = line_mem[k-1][col];
        for (int k = 0; k < KMAX - 1; k++)
            line_mem[k][col] = vec[k];
        for (int k = 0; k < KMAX; k++)
        begin
            for (int c = KMAX - 1; c > 0; c--)
                win[k][c] = win[k][c-1];
            win[k][0] = vec[k];
        end
        // one result per filter once the window is full
        if (row + 1 >= kr && col + 1 >= kc)
        begin
            for (int f = 0; f < fc; f++)
            begin
                acc = 0;
                for (int i = 0; i < kr; i++)
                    for (int j = 0; j < kc; j++)
                        acc += longint'($signed(win[kr-1-i][kc-1-j]))
                             * longint'($signed(wts[f][i][j]));
                if (acc <= 0)
                    act = 0;
                else
                begin
                    act = 64'(acc) >> reg_shift;
                    if (act > 32767)
                        act = 32767;
                end
                res.filter_index = f[c2d_pkg::FIDX_W-1:0];
                res.out_row      = c2d_pkg::POS_W'(row + 1 - kr);
                res.out_col      = c2d_pkg::POS_W'(col + 1 - kc);
                res.activation   = act[c2d_pkg::ACT_W-1:0];
                res.last         = (f + 1 == fc);
                pending_results.insert(pending_results.size(), res);
            end
        end
        col++;
        if (col >= iw)
        begin
            col = 0;
            row++;
            if (row >= ih)
                row = 0;
        end
        col_pos = col & 10'h3FF;
        row_pos = row & 10'h3FF;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
        n_err++;
    endtask

    // sends one item; called right after a rising edge, returns at the accepting edge
    task automatic send_item(c2d_pkg::in_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        conv_predict(it);
    endtask

    // lowers valid after the last item of a burst
    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // register write, only while idle; one cycle of write enable
    task automatic write_reg(logic [2:0] idx, int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= c2d_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            c2d_pkg::REG_KERNEL_ROWS:  reg_kr    = value & 3'h7;
            c2d_pkg::REG_KERNEL_COLS:  reg_kc    = value & 3'h7;
            c2d_pkg::REG_IMAGE_WIDTH:  reg_iw    = value & 11'h7FF;
            c2d_pkg::REG_IMAGE_HEIGHT: reg_ih    = value & 11'h7FF;
            c2d_pkg::REG_FILTER_COUNT: reg_fc    = value & 4'hF;
            c2d_pkg::REG_RESULT_SHIFT: reg_shift = value & 5'h1F;
            default: ;
        endcase
        if (idx <= c2d_pkg::REG_IMAGE_HEIGHT)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        @(posedge clk);
    endtask

    task automatic set_geometry(int unsigned kr, int unsigned kc, int unsigned iw,
                                int unsigned ih, int unsigned fc, int unsigned sh);
        write_reg(c2d_pkg::REG_KERNEL_ROWS, kr);
        write_reg(c2d_pkg::REG_KERNEL_COLS, kc);
        write_reg(c2d_pkg::REG_IMAGE_WIDTH, iw);
        write_reg(c2d_pkg::REG_IMAGE_HEIGHT, ih);
        write_reg(c2d_pkg::REG_FILTER_COUNT, fc);
        write_reg(c2d_pkg::REG_RESULT_SHIFT, sh);
    endtask

    function automatic c2d_pkg::in_item_t make_pixel(logic signed [15:0] v);
        c2d_pkg::in_item_t it;
        it.cmd           = c2d_pkg::CMD_PIXEL;
        it.weight_filter = 3'($urandom);
        it.weight_row    = 3'($urandom);
        it.weight_col    = 3'($urandom);
        it.sample        = v;
        return it;
    endfunction

    function automatic c2d_pkg::in_item_t make_weight(int f, int r, int c,
                                                      logic signed [15:0] v);
        c2d_pkg::in_item_t it;
        it.cmd           = c2d_pkg::CMD_WEIGHT;
        it.weight_filter = 3'(f);
        it.weight_row    = 3'(r);
        it.weight_col    = 3'(c);
        it.sample        = v;
        return it;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(511)) - 256);
            2:       return 16'($urandom_range(2047));
            default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    // result checker and receiver stalls
    initial
    begin : result_check
        logic               fire;
        c2d_pkg::out_item_t got;
        c2d_pkg::out_item_t want;
        forever
        begin
            @(negedge clk);
            fire = out_valid && out_ready;
            got  = out_item;
            @(posedge clk);
            if (fire)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, filter", got.filter_index, -1);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.filter_index !== want.filter_index)
                        report_mismatch("filter_index", got.filter_index, want.filter_index);
                    if (got.out_row !== want.out_row)
                        report_mismatch("out_row", got.out_row, want.out_row);
                    if (got.out_col !== want.out_col)
                        report_mismatch("out_col", got.out_col, want.out_col);
                    if (got.activation !== want.activation)
                        report_mismatch("activation", got.activation, want.activation);
                    if (got.last !== want.last)
                        report_mismatch("last", got.last, want.last);
                end
            end
            if (hold_cycles > 0)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off countdown
    initial
    begin : hold_count
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
                hold_cycles = hold_cycles - 1;
        end
    end

    // extreme fields, weight address corners, extreme shifts
    task automatic test_extremes();
        set_geometry(1, 1, 1024, 1024, 8, 0);
        send_item(make_weight(0, 0, 0, 16'sh8000));
        send_item(make_weight(7, 0, 0, 16'sh7FFF));
        send_item(make_weight(3, 0, 0, 16'sh4000));
        send_item(make_weight(5, 4, 4, 16'sh1234));
        send_item(make_weight(6, 5, 0, 16'sh7777));
        send_item(make_weight(6, 0, 7, 16'sh5555));
        send_item(make_weight(6, 7, 7, 16'sh2222));
        send_item(make_pixel(16'sh7FFF));
        send_item(make_pixel(16'sh8000));
        send_item(make_pixel(16'sh0000));
        send_item(make_pixel(16'sh0001));
        stop_sending();
        wait_drained();
        write_reg(c2d_pkg::REG_RESULT_SHIFT, 31);
        send_item(make_pixel(16'sh8000));
        send_item(make_pixel(16'sh7FFF));
        stop_sending();
        wait_drained();
        // largest window, tiny frame
        set_geometry(5, 5, 5, 5, 1, 14);
        for (int i = 0; i < 12; i++)
            send_item(make_pixel(rand_sample()));
        stop_sending();
        wait_drained();
    endtask

    // kernel larger than the image, clamped and unknown registers
    task automatic test_odd_config();
        write_reg(3'd6, 11'h7FF);
        write_reg(3'd7, 11'h155);
        set_geometry(5, 5, 3, 3, 15, 12);
        for (int i = 0; i < 10; i++)
            send_item(make_pixel(rand_sample()));
        stop_sending();
        wait_drained();
        set_geometry(0, 7, 0, 2047, 0, 13);
        for (int i = 0; i < 8; i++)
            send_item(make_pixel(rand_sample()));
        stop_sending();
        wait_drained();
    endtask

    // random frames across idling phases
    task automatic test_random_frames(int items);
        int left;
        left = items;
        while (left > 0)
        begin
            set_geometry($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 9),
                         $urandom_range(1, 7), $urandom_range(1, 8), $urandom_range(8, 18));
            for (int i = 0; i < 40 && left > 0; i++, left--)
            begin
                if ($urandom_range(99) < 15)
                    send_item(make_weight($urandom_range(7), $urandom_range(7),
                                          $urandom_range(7), rand_sample()));
                else
                    send_item(make_pixel(rand_sample()));
            end
            stop_sending();
            wait_drained();
        end
    endtask

    // receiver holds off while pixels keep coming
    task automatic test_backpressure();
        set_geometry(1, 1, 8, 8, 8, 10);
        hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_item(make_pixel(rand_sample()));
        stop_sending();
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        n_err          = 0;
        n_results      = 0;
        n_pixels       = 0;
        n_weights      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        model_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_odd_config();
        // load one random weight in every even row of each filter, at a random column
        for (int f = 0; f < FMAX; f++)
            for (int r = 0; r < KMAX; r += 2)
                send_item(make_weight(f, r, $urandom_range(4), rand_sample()));
        stop_sending();
        wait_drained();
        test_random_frames(80);
        send_idle_pct = 86;
        test_random_frames(70);
        send_idle_pct  = 0;
        recv_stall_pct = 86;
        test_random_frames(70);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        test_random_frames(70);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();

        wait_drained();
        repeat (50) @(posedge clk);
        $display("covered %0d pixels and %0d weight writes, %0d results checked",
                 n_pixels, n_weights, n_results);
        $display("kernels 1..5, frame wrap, clamped registers, idling and long hold-off");
        if (n_err == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/c2d_pkg.sv
rtl/c2d_fifo.sv
rtl/c2d_front.sv
rtl/c2d_back.sv
rtl/conv2d_valid_relu_stream.sv
rtl/c2d_checker.sv
tb/tb_conv2d_valid_relu_stream.sv
